/* rtl/core/b64_pkg.sv */
// Shared types, constants and character mapping functions for the base64 codec.
package b64_pkg;

  localparam int unsigned GrpMax = 5;
  localparam int unsigned CntW   = 3;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChPad    = 8'h3D;
  localparam logic [7:0] ChNl     = 8'h0A;

  localparam logic [5:0] SxPlus  = 6'd62;
  localparam logic [5:0] SxSlash = 6'd63;

  // Config register indexes
  localparam logic RegDecodeMode = 1'b0;

  // Result group handed from the datapath to the output serializer
  typedef struct packed {
    logic [GrpMax-1:0][7:0] data;
    logic [CntW-1:0]        cnt;
  } grp_t;

  // Sextet to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v < 6'd26) begin
      ch = ChUpperA + {2'b00, v};
    end else if (v < 6'd52) begin
      ch = ChLowerA + {2'b00, v} - 8'd26;
    end else if (v < SxPlus) begin
      ch = ChZero + {2'b00, v} - 8'd52;
    end else if (v == SxPlus) begin
      ch = ChPlus;
    end else begin
      ch = ChSlash;
    end
    return ch;
  endfunction

  // Character to {valid, sextet}; zero for characters outside the alphabet
  function automatic logic [6:0] dec_char(input logic [7:0] ch);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'd0;
    r = 7'd0;
    if (ch >= ChUpperA && ch <= ChUpperZ) begin
      t = ch - ChUpperA;
      r = {1'b1, t[5:0]};
    end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
      t = ch - ChLowerA + 8'd26;
      r = {1'b1, t[5:0]};
    end else if (ch >= ChZero && ch <= ChNine) begin
      t = ch - ChZero + 8'd52;
      r = {1'b1, t[5:0]};
    end else if (ch == ChPlus) begin
      r = {1'b1, SxPlus};
    end else if (ch == ChSlash) begin
      r = {1'b1, SxSlash};
    end
    return r;
  endfunction

endpackage

/* rtl/core/b64_core.sv */
// Codec state and per-beat encode/decode logic producing one result group.
module b64_core
  import b64_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       decode_mode_i,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       eos_i,
  output logic       push_o,
  output grp_t       grp_o
);

  logic [15:0]     held_bytes_q, held_bytes_d;
  logic [1:0]      held_count_q, held_count_d;
  logic [3:0][6:0] win_q, win_d;
  logic [2:0]      win_fill_q, win_fill_d;

  grp_t enc_grp, dec_grp;

  // Encoder
  always_comb begin
    logic [1:0] c;
    logic [1:0] n_m1;
    logic [7:0] g0, g1, g2;
    c = (held_count_q == 2'd3) ? 2'd2 : held_count_q;
    n_m1 = c;
    g0 = 8'd0;
    g1 = 8'd0;
    g2 = 8'd0;
    if (c >= 2'd1) g0 = held_bytes_q[15:8];
    if (c >= 2'd2) g1 = held_bytes_q[7:0];
    unique case (c)
      2'd0:    g0 = in_byte_i;
      2'd1:    g1 = in_byte_i;
      default: g2 = in_byte_i;
    endcase
    held_bytes_d = held_bytes_q;
    held_count_d = held_count_q;
    enc_grp      = '0;
    if (c != 2'd2 && !eos_i) begin
      if (c == 2'd0) held_bytes_d = {in_byte_i, 8'd0};
      else           held_bytes_d = {held_bytes_q[15:8], in_byte_i};
      held_count_d = c + 2'd1;
    end else begin
      enc_grp.data[0] = enc_char(g0[7:2]);
      enc_grp.data[1] = enc_char({g0[1:0], g1[7:4]});
      enc_grp.data[2] = (n_m1 >= 2'd1) ? enc_char({g1[3:0], g2[7:6]}) : ChPad;
      enc_grp.data[3] = (n_m1 >= 2'd2) ? enc_char(g2[5:0]) : ChPad;
      enc_grp.data[4] = ChNl;
      enc_grp.cnt     = eos_i ? CntW'(5) : CntW'(4);
      held_bytes_d    = 16'd0;
      held_count_d    = 2'd0;
    end
  end

  // Decoder
  always_comb begin
    logic [1:0]      f;
    logic [3:0][6:0] w;
    logic [2:0]      fill;
    f = (win_fill_q > 3'd3) ? 2'd3 : win_fill_q[1:0];
    w = win_q;
    for (int i = 0; i < 4; i++) begin
      if (f == 2'(i)) w[i] = dec_char(in_byte_i);
    end
    fill    = {1'b0, f} + 3'd1;
    dec_grp = '0;
    win_d   = w;
    if (fill == 3'd4) begin
      if (!w[0][6] || !w[1][6]) begin
        // drop the oldest character
        win_d = {7'd0, w[3], w[2], w[1]};
        fill  = 3'd3;
      end else begin
        dec_grp.data[0] = {w[0][5:0], w[1][5:4]};
        dec_grp.data[1] = {w[1][3:0], w[2][5:2]};
        dec_grp.data[2] = {w[2][1:0], w[3][5:0]};
        if (!w[2][6])      dec_grp.cnt = CntW'(1);
        else if (!w[3][6]) dec_grp.cnt = CntW'(2);
        else               dec_grp.cnt = CntW'(3);
        win_d = '0;
        fill  = 3'd0;
      end
    end
    if (in_byte_i == ChNl || eos_i) begin
      win_d = '0;
      fill  = 3'd0;
    end
    win_fill_d = fill;
  end

  assign grp_o  = decode_mode_i ? dec_grp : enc_grp;
  assign push_o = accept_i && (grp_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bytes_q <= '0;
      held_count_q <= '0;
      win_q        <= '0;
      win_fill_q   <= '0;
    end else if (accept_i) begin
      if (decode_mode_i) begin
        win_q      <= win_d;
        win_fill_q <= win_fill_d;
      end else begin
        held_bytes_q <= held_bytes_d;
        held_count_q <= held_count_d;
      end
    end
  end

endmodule

/* rtl/core/b64_ser.sv */
// Two-slot result buffer that serializes each group one beat at a time.
module b64_ser
  import b64_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  grp_t       grp_i,
  output logic       free_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast
);

  logic            pend_valid_q, pend_valid_d;
  grp_t            pend_q;
  logic            cur_valid_q, cur_valid_d;
  grp_t            cur_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic            last, done, move;

  assign last = (idx_q == cur_q.cnt - CntW'(1));
  assign done = cur_valid_q && m_axis_tready && last;
  assign move = pend_valid_q && (!cur_valid_q || done);

  assign free_o        = !pend_valid_q || move;
  assign m_axis_tvalid = cur_valid_q;
  assign m_axis_tdata  = cur_q.data[idx_q];
  assign m_axis_tlast  = last;

  always_comb begin
    pend_valid_d = push_i || (pend_valid_q && !move);
    cur_valid_d  = move || (cur_valid_q && !done);
    idx_d        = idx_q;
    if (move) begin
      idx_d = '0;
    end else if (cur_valid_q && m_axis_tready) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      cur_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      cur_valid_q  <= cur_valid_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) pend_q <= grp_i;
    if (move)   cur_q  <= pend_q;
  end

endmodule

/* rtl/core/base64_codec.sv */
// Top level of the base64 codec: config register, datapath and output serializer.
//
// Input stream (s_axis_*): one byte per beat; tlast marks the final byte of
// a stream. Output stream (m_axis_*): one character or decoded byte per beat;
// tlast marks the last result caused by an input byte. Inputs that cause no
// result (bytes held in an encode group, partial decode windows) produce no beat.
// decode_mode at APB address 0, bit 0: 0 encodes, 1 decodes. Write it only
// while the block is idle; encoder and decoder state are kept across changes.
// The first result of a byte is registered in the pending slot and then in the
// current slot, which it enters once that slot is free, before it is offered.
// Throughput: a byte is taken every cycle while the two-group result buffer
// has room; the output port drains one beat per cycle while m_axis_tready
// is high, so a full encode group (four characters, five at end of stream)
// sets the sustained rate. Reset clears the held bytes, the character window
// and the mode, and empties the result buffer. When the receiver stalls, the
// current beat holds and one more group can queue before s_axis_tready drops.
module base64_codec
  import b64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // run_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic decode_mode_q;
  logic accept, push, free;
  grp_t grp;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDecodeMode) ? {31'd0, decode_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegDecodeMode) begin
      decode_mode_q <= pwdata[0];
    end
  end

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  b64_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .decode_mode_i (decode_mode_q),
    .accept_i      (accept),
    .in_byte_i     (s_axis_tdata),
    .eos_i         (s_axis_tlast),
    .push_o        (push),
    .grp_o         (grp)
  );

  b64_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .grp_i         (grp),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* test/base64_codec_tb.sv */
// Self-checking testbench for base64_codec: encode and decode streams checked beat by beat.
module base64_codec_tb;
  import b64_pkg::*;

  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [2:0]  ModeAddr   = {RegDecodeMode, 2'b00};
  localparam logic [2:0]  SpareAddr  = 3'd4;
  localparam logic [31:0] ModeEncode = 32'd0;
  localparam logic [31:0] ModeDecode = 32'd1;
  localparam int          RandItems  = 22;
  localparam int          HoldCycles = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0;   // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] out_byte
  logic        m_axis_tlast;           // run_last
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the codec state
  logic        mode_q      = 1'b0;
  logic [15:0] held_q      = 16'd0;
  logic [1:0]  held_cnt_q  = 2'd0;
  logic [6:0]  window_q [4] = '{default: 7'd0};
  logic [2:0]  fill_q      = 3'd0;

  out_beat_t expected_beats [$];
  int        mismatches     = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  logic      hold_active    = 1'b0;

  base64_codec dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return Alphabet[8*(63-int'(v)) +: 8];
  endfunction

  // {valid, sextet}, zero for anything outside the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] ch);
    for (int i = 0; i < 64; i++) begin
      if (sextet_char(6'(i)) == ch) return {1'b1, 6'(i)};
    end
    return 7'd0;
  endfunction

  // Four characters of a group of n data bytes, first character in the top byte
  function automatic logic [31:0] encode_group(input logic [7:0] g0, input logic [7:0] g1,
                                               input logic [7:0] g2, input int n);
    logic [7:0] c2;
    logic [7:0] c3;
    c2 = (n > 1) ? sextet_char({g1[3:0], g2[7:6]}) : ChPad;
    c3 = (n > 2) ? sextet_char(g2[5:0]) : ChPad;
    return {sextet_char(g0[7:2]), sextet_char({g0[1:0], g1[7:4]}), c2, c3};
  endfunction

  function automatic void push_beat(input logic [7:0] d);
    expected_beats.push_back('{data: d, last: 1'b0});
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < 4; i++) window_q[i] = 7'd0;
    fill_q = 3'd0;
  endfunction

  function automatic void predict_step(input logic [7:0] b, input logic eos);
    logic [7:0]  g0;
    logic [7:0]  g1;
    logic [7:0]  g2;
    logic [31:0] quad;
    out_beat_t   tail;
    int          n;
    int          idx;
    int          first;
    first = expected_beats.size();
    if (mode_q == ModeDecode[0]) begin
      idx = (fill_q > 3'd3) ? 3 : int'(fill_q);
      window_q[idx] = char_sextet(b);
      fill_q = 3'(idx + 1);
      if (fill_q == 3'd4) begin
        if (!window_q[0][6] || !window_q[1][6]) begin
          // drop the oldest character
          window_q[0] = window_q[1];
          window_q[1] = window_q[2];
          window_q[2] = window_q[3];
          window_q[3] = 7'd0;
          fill_q = 3'd3;
        end else begin
          push_beat({window_q[0][5:0], window_q[1][5:4]});
          if (window_q[2][6]) begin
            push_beat({window_q[1][3:0], window_q[2][5:2]});
            if (window_q[3][6]) push_beat({window_q[2][1:0], window_q[3][5:0]});
          end
          clear_window();
        end
      end
      if (b == ChNl || eos) clear_window();
    end else begin
      g0 = (held_cnt_q >= 2'd1) ? held_q[15:8] : 8'h00;
      g1 = (held_cnt_q >= 2'd2) ? held_q[7:0] : 8'h00;
      g2 = 8'h00;
      case (held_cnt_q)
        2'd0:    g0 = b;
        2'd1:    g1 = b;
        default: g2 = b;
      endcase
      n = int'(held_cnt_q) + 1;
      if (n < 3 && !eos) begin
        if (held_cnt_q == 2'd0) held_q = {b, 8'h00};
        else held_q[7:0] = b;
        held_cnt_q = 2'(n);
      end else begin
        quad = encode_group(g0, g1, g2, n);
        push_beat(quad[31:24]);
        push_beat(quad[23:16]);
        push_beat(quad[15:8]);
        push_beat(quad[7:0]);
        if (eos) push_beat(ChNl);
        held_q = 16'd0;
        held_cnt_q = 2'd0;
      end
    end
    if (expected_beats.size() > first) begin
      tail = expected_beats.pop_back();
      tail.last = 1'b1;
      expected_beats.push_back(tail);
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: data %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected data %h last %b, got data %h last %b",
                     want.data, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // Receiver readiness; hold low while a hold-off runs
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_step(b, eos);
  endtask

  task automatic send_text(input string s, input logic eos_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eos_end && (i == s.len() - 1));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    // cover bytes still in flight that cause no result
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ModeAddr) mode_q = data[0];
  endtask

  task automatic test_encode_directed();
    set_idle(0, 0);
    write_reg(ModeAddr, ModeEncode);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte("M", 1'b1);
    send_text("Ma", 1'b1);
    // end of stream on the byte that completes a group
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
    // a write past the register map must not change the mode
    write_reg(SpareAddr, ModeDecode);
    send_text("Man", 1'b0);
  endtask

  task automatic test_decode_directed();
    write_reg(ModeAddr, 32'hFFFF_FFFF);
    send_text("////", 1'b0);
    send_text("TW=u", 1'b0);
    send_text("TWF=", 1'b0);
    send_text("=TWFu", 1'b1);
    send_text("T\n", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("AB", 1'b0);
    send_byte("C", 1'b1);
  endtask

  task automatic test_mode_switch();
    write_reg(ModeAddr, 32'hFFFF_FFFE);
    send_byte("M", 1'b0);
    write_reg(ModeAddr, ModeDecode);
    send_text("TW", 1'b0);
    write_reg(ModeAddr, ModeEncode);
    send_text("an", 1'b0);
    write_reg(ModeAddr, ModeDecode);
    send_text("Fu", 1'b0);
  endtask

  task automatic test_backpressure();
    set_idle(0, 0);
    write_reg(ModeAddr, ModeEncode);
    fork
      begin
        hold_active <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active <= 1'b0;
      end
    join_none
    for (int i = 0; i < 45; i++) send_byte(8'($urandom_range(0, 255)), (i % 9) == 8);
  endtask

  task automatic rand_encode(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom_range(0, 255)), (i == len - 1) && ($urandom_range(9) != 0));
      sent += len;
    end
  endtask

  task automatic rand_decode(input int items);
    logic [7:0]  txt [$];
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [31:0] quad;
    logic        tag_end;
    int          sent;
    int          len;
    int          n;
    sent = 0;
    while (sent < items) begin
      txt.delete();
      if ($urandom_range(99) < 15) begin
        len = $urandom_range(1, 6);
        repeat (len) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        // well-formed text for a random data run, sometimes with one bad character
        len = $urandom_range(1, 12);
        for (int g = 0; g < len; g += 3) begin
          n  = (len - g > 3) ? 3 : len - g;
          d0 = 8'($urandom_range(0, 255));
          d1 = (n > 1) ? 8'($urandom_range(0, 255)) : 8'h00;
          d2 = (n > 2) ? 8'($urandom_range(0, 255)) : 8'h00;
          quad = encode_group(d0, d1, d2, n);
          txt.push_back(quad[31:24]);
          txt.push_back(quad[23:16]);
          txt.push_back(quad[15:8]);
          txt.push_back(quad[7:0]);
        end
        txt.push_back(ChNl);
        if ($urandom_range(3) == 0)
          txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      end
      tag_end = 1'($urandom_range(1));
      for (int i = 0; i < txt.size(); i++) send_byte(txt[i], tag_end && (i == txt.size() - 1));
      sent += txt.size();
    end
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct);
    set_idle(send_pct, recv_pct);
    write_reg(ModeAddr, ModeEncode);
    rand_encode(RandItems);
    write_reg(ModeAddr, ModeDecode);
    rand_decode(RandItems);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_directed();
    test_decode_directed();
    test_mode_switch();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(63, 0);
    test_random_phase(0, 63);
    test_random_phase(6, 6);
    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 20000 && expected_beats.size() != 0; i++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* base64_codec.f */
rtl/core/b64_pkg.sv
rtl/core/b64_core.sv
rtl/core/b64_ser.sv
rtl/core/base64_codec.sv
test/base64_codec_tb.sv
